// ===== design/ipv4fd_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 forwarding decision package
// Shared widths, register indexes, action codes and protocol constants.
// ----------------------------------------------------------------------------
package ipv4fd_pkg;

  // Number of interfaces that take part in matching (1 to 3).
  localparam int unsigned NumIfaces  = 3;
  // Interface register slots provided by the configuration port.
  localparam int unsigned IfaceSlots = 3;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned IfaceW  = 2;
  localparam int unsigned TtlW    = 8;
  localparam int unsigned SumW    = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ActionW = 3;
  localparam int unsigned CfgIdxW = 3;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegIf0Addr  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIf0Mask  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIf1Addr  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIf1Mask  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIf2Addr  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIf2Mask  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegGateway  = 3'd6;

  // Result action codes.
  localparam logic [ActionW-1:0] ActLocal     = 3'd0;
  localparam logic [ActionW-1:0] ActForward   = 3'd1;
  localparam logic [ActionW-1:0] ActNoRoute   = 3'd2;
  localparam logic [ActionW-1:0] ActSameIface = 3'd3;
  localparam logic [ActionW-1:0] ActTtlError  = 3'd4;
  localparam logic [ActionW-1:0] ActTtlQuiet  = 3'd5;

  // Protocol and ICMP type codes.
  localparam logic [ByteW-1:0] ProtoIcmp     = 8'd1;
  localparam logic [ByteW-1:0] IcmpEchoReply = 8'd0;
  localparam logic [ByteW-1:0] IcmpEcho      = 8'd8;

  // Checksum adjustment for a TTL decrement of one.
  localparam logic [SumW-1:0] TtlSumStep = 16'h0100;

endpackage

// ===== design/ipv4_forward_decision.sv =====
// An accepted input beat passes through the input register and the result register to the master side.
// Throughput: one header per cycle while the master side accepts; an input register feeds a result register.
// Back-pressure on the master side holds the result register; the input side
// stalls only once both stages hold a beat.
// Reset (rst_ni low, asynchronous) empties both stages and clears all
// configuration registers to zero.
// ----------------------------------------------------------------------------
// IPv4 forwarding decision
// Local delivery check, masked subnet route lookup with default gateway,
// same-interface drop, TTL expiry handling and TTL/checksum update.
// ----------------------------------------------------------------------------
module ipv4_forward_decision (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ipv4fd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ipv4fd_pkg::AddrW-1:0]      cfg_data_i,
  // Header input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: arrival_iface[1:0], dest_address[33:2], hop_limit[41:34],
  // header_sum[57:42], protocol_number[65:58], icmp_kind[73:66], zero pad
  input  logic [ipv4fd_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: locally_originated[0]
  input  logic                              s_axis_tuser,
  // Decision output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: target_iface[1:0], new_hop_limit[9:2],
  // new_header_sum[25:10], zero pad
  output logic [ipv4fd_pkg::OutDataW-1:0]   m_axis_tdata,
  // tuser: action[2:0]
  output logic [ipv4fd_pkg::ActionW-1:0]    m_axis_tuser
);

  // Configuration registers.
  logic [ipv4fd_pkg::AddrW-1:0] addr_q [ipv4fd_pkg::IfaceSlots];
  logic [ipv4fd_pkg::AddrW-1:0] mask_q [ipv4fd_pkg::IfaceSlots];
  logic [ipv4fd_pkg::AddrW-1:0] gateway_q;

  // Input stage.
  logic                           in_valid_q;
  logic                           lorig_q;
  logic [ipv4fd_pkg::IfaceW-1:0]  arrival_q;
  logic [ipv4fd_pkg::AddrW-1:0]   dest_q;
  logic [ipv4fd_pkg::TtlW-1:0]    ttl_q;
  logic [ipv4fd_pkg::SumW-1:0]    sum_q;
  logic [ipv4fd_pkg::ByteW-1:0]   proto_q;
  logic [ipv4fd_pkg::ByteW-1:0]   kind_q;

  // Result stage.
  logic                            out_valid_q;
  logic [ipv4fd_pkg::ActionW-1:0]  action_q, action_d;
  logic [ipv4fd_pkg::IfaceW-1:0]   target_q, target_d;
  logic [ipv4fd_pkg::TtlW-1:0]     new_ttl_q, new_ttl_d;
  logic [ipv4fd_pkg::SumW-1:0]     new_sum_q, new_sum_d;

  logic res_ready;
  logic in_advance;

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ipv4fd_pkg::IfaceSlots; i++) begin
        addr_q[i] <= '0;
        mask_q[i] <= '0;
      end
      gateway_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ipv4fd_pkg::RegIf0Addr: addr_q[0] <= cfg_data_i;
        ipv4fd_pkg::RegIf0Mask: mask_q[0] <= cfg_data_i;
        ipv4fd_pkg::RegIf1Addr: addr_q[1] <= cfg_data_i;
        ipv4fd_pkg::RegIf1Mask: mask_q[1] <= cfg_data_i;
        ipv4fd_pkg::RegIf2Addr: addr_q[2] <= cfg_data_i;
        ipv4fd_pkg::RegIf2Mask: mask_q[2] <= cfg_data_i;
        ipv4fd_pkg::RegGateway: gateway_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the result register takes a new value when empty or when drained.
  assign res_ready     = !out_valid_q || m_axis_tready;
  assign in_advance    = in_valid_q && res_ready;
  assign s_axis_tready = !in_valid_q || res_ready;

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload, unpacked from the beat.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      lorig_q   <= s_axis_tuser;
      arrival_q <= s_axis_tdata[1:0];
      dest_q    <= s_axis_tdata[33:2];
      ttl_q     <= s_axis_tdata[41:34];
      sum_q     <= s_axis_tdata[57:42];
      proto_q   <= s_axis_tdata[65:58];
      kind_q    <= s_axis_tdata[73:66];
    end
  end

  // Decision logic between the input and result registers.
  always_comb begin
    logic                          local_hit;
    logic [ipv4fd_pkg::IfaceW-1:0] local_idx;
    logic                          dest_hit;
    logic [ipv4fd_pkg::IfaceW-1:0] dest_idx;
    logic                          gw_hit;
    logic [ipv4fd_pkg::IfaceW-1:0] gw_idx;
    logic                          route_ok;
    logic [ipv4fd_pkg::IfaceW-1:0] route_idx;
    logic                          arrival_ok;
    logic                          quiet;
    logic [ipv4fd_pkg::SumW:0]     sum_ext;

    local_hit = 1'b0;
    local_idx = '0;
    dest_hit  = 1'b0;
    dest_idx  = '0;
    gw_hit    = 1'b0;
    gw_idx    = '0;

    // Lowest-numbered interface wins in every search.
    for (int i = 0; i < ipv4fd_pkg::NumIfaces; i++) begin
      if (!local_hit && dest_q == addr_q[i]) begin
        local_hit = 1'b1;
        local_idx = ipv4fd_pkg::IfaceW'(i);
      end
      if (!dest_hit && ((dest_q & mask_q[i]) == (addr_q[i] & mask_q[i]))) begin
        dest_hit = 1'b1;
        dest_idx = ipv4fd_pkg::IfaceW'(i);
      end
      if (!gw_hit && ((gateway_q & mask_q[i]) == (addr_q[i] & mask_q[i]))) begin
        gw_hit = 1'b1;
        gw_idx = ipv4fd_pkg::IfaceW'(i);
      end
    end

    route_ok   = dest_hit || gw_hit;
    route_idx  = dest_hit ? dest_idx : gw_idx;
    arrival_ok = {30'd0, arrival_q} < 32'(ipv4fd_pkg::NumIfaces);
    quiet      = (proto_q == ipv4fd_pkg::ProtoIcmp) &&
                 (kind_q != ipv4fd_pkg::IcmpEcho) &&
                 (kind_q != ipv4fd_pkg::IcmpEchoReply);

    // Ones-complement add with end-around carry; the carry cannot ripple again.
    sum_ext = {1'b0, sum_q} + {1'b0, ipv4fd_pkg::TtlSumStep};

    action_d  = ipv4fd_pkg::ActNoRoute;
    target_d  = '0;
    new_ttl_d = ttl_q;
    new_sum_d = sum_q;

    if (!lorig_q && local_hit) begin
      action_d = ipv4fd_pkg::ActLocal;
      target_d = local_idx;
    end else if (!route_ok) begin
      action_d = ipv4fd_pkg::ActNoRoute;
    end else if (lorig_q) begin
      action_d = ipv4fd_pkg::ActForward;
      target_d = route_idx;
    end else if (route_idx == arrival_q) begin
      action_d = ipv4fd_pkg::ActSameIface;
      target_d = route_idx;
    end else if (ttl_q <= ipv4fd_pkg::TtlW'(1)) begin
      if (!arrival_ok) begin
        action_d = ipv4fd_pkg::ActTtlQuiet;
      end else begin
        action_d = quiet ? ipv4fd_pkg::ActTtlQuiet : ipv4fd_pkg::ActTtlError;
        target_d = arrival_q;
      end
    end else begin
      action_d  = ipv4fd_pkg::ActForward;
      target_d  = route_idx;
      new_ttl_d = ttl_q - ipv4fd_pkg::TtlW'(1);
      new_sum_d = sum_ext[ipv4fd_pkg::SumW-1:0] + ipv4fd_pkg::SumW'(sum_ext[ipv4fd_pkg::SumW]);
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_advance) begin
      action_q  <= action_d;
      target_q  <= target_d;
      new_ttl_q <= new_ttl_d;
      new_sum_q <= new_sum_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = action_q;
  assign m_axis_tdata  = {6'd0, new_sum_q, new_ttl_q, target_q};

`ifndef SYNTHESIS
  // A header leaving the input register always lands in the result register.
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_advance |=> out_valid_q)
    else $error("advanced header did not reach the result register");

  // The input side only stalls when both stages hold a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with a free stage");

  // A packet without a route always reports interface zero.
  a_noroute_iface: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && action_q == ipv4fd_pkg::ActNoRoute) |-> (target_q == '0))
    else $error("no-route result with non-zero interface");

  // Time-exceeded errors go out on an existing interface.
  a_ttl_error_iface: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && action_q == ipv4fd_pkg::ActTtlError) |->
      ({30'd0, target_q} < 32'(ipv4fd_pkg::NumIfaces)))
    else $error("time-exceeded result on a missing interface");
`endif

endmodule

// ===== test/tb_ipv4_forward_decision.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv4 forwarding decision testbench
// Drives header beats and register writes into the block. A scoreboard
// predicts each decision from its own copy of the interface registers and
// compares every result beat with the oldest prediction. Both stream sides
// idle at random. The interface settings change between phases while the
// block is empty.
// ----------------------------------------------------------------------------
module tb_ipv4_forward_decision;

  typedef logic [ipv4fd_pkg::CfgIdxW-1:0] cfg_index_t;
  typedef logic [ipv4fd_pkg::AddrW-1:0]   addr_t;
  typedef logic [ipv4fd_pkg::IfaceW-1:0]  iface_t;
  typedef logic [ipv4fd_pkg::TtlW-1:0]    ttl_t;
  typedef logic [ipv4fd_pkg::SumW-1:0]    sum_t;
  typedef logic [ipv4fd_pkg::ByteW-1:0]   byte_t;
  typedef logic [ipv4fd_pkg::ActionW-1:0] action_t;

  typedef struct packed {
    logic    locally_originated;
    iface_t  arrival_iface;
    addr_t   dest_address;
    ttl_t    hop_limit;
    sum_t    header_sum;
    byte_t   protocol_number;
    byte_t   icmp_kind;
  } header_t;

  typedef struct packed {
    action_t action;
    iface_t  target_iface;
    ttl_t    new_hop_limit;
    sum_t    new_header_sum;
  } decision_t;

  localparam int NoIface = -1;
  localparam byte_t ProtoTcp         = 8'd6;
  localparam byte_t ProtoUdp         = 8'd17;
  localparam byte_t IcmpUnreachable  = 8'd3;
  localparam byte_t IcmpTimeExceeded = 8'd11;

  // Scoreboard: holds the register copy and the queue of predicted decisions.
  class decision_scoreboard;
    addr_t       iface_addr [ipv4fd_pkg::IfaceSlots];
    addr_t       iface_mask [ipv4fd_pkg::IfaceSlots];
    addr_t       gateway;
    decision_t   pending [$];
    int          errors;

    function new();
      foreach (iface_addr[i]) begin
        iface_addr[i] = '0;
        iface_mask[i] = '0;
      end
      gateway = '0;
      errors  = 0;
    endfunction

    function void write_reg(cfg_index_t idx, addr_t value);
      case (idx)
        ipv4fd_pkg::RegIf0Addr: iface_addr[0] = value;
        ipv4fd_pkg::RegIf0Mask: iface_mask[0] = value;
        ipv4fd_pkg::RegIf1Addr: iface_addr[1] = value;
        ipv4fd_pkg::RegIf1Mask: iface_mask[1] = value;
        ipv4fd_pkg::RegIf2Addr: iface_addr[2] = value;
        ipv4fd_pkg::RegIf2Mask: iface_mask[2] = value;
        ipv4fd_pkg::RegGateway: gateway       = value;
        default: ;
      endcase
    endfunction

    // First interface whose subnet holds the address, or none.
    function int subnet_match(addr_t addr);
      for (int i = 0; i < ipv4fd_pkg::NumIfaces; i++) begin
        if ((addr & iface_mask[i]) == (iface_addr[i] & iface_mask[i])) return i;
      end
      return NoIface;
    endfunction

    function decision_t decide(header_t h);
      decision_t                 d;
      int                        route;
      logic [ipv4fd_pkg::SumW:0] sum_wide;
      d.action         = ipv4fd_pkg::ActNoRoute;
      d.target_iface   = '0;
      d.new_hop_limit  = h.hop_limit;
      d.new_header_sum = h.header_sum;
      // Received packets addressed to one of our interfaces stay here.
      if (!h.locally_originated) begin
        for (int i = 0; i < ipv4fd_pkg::NumIfaces; i++) begin
          if (h.dest_address == iface_addr[i]) begin
            d.action       = ipv4fd_pkg::ActLocal;
            d.target_iface = ipv4fd_pkg::IfaceW'(i);
            return d;
          end
        end
      end
      route = subnet_match(h.dest_address);
      if (route == NoIface) route = subnet_match(gateway);
      if (route == NoIface) begin
        d.action = ipv4fd_pkg::ActNoRoute;
      end else if (h.locally_originated) begin
        d.action       = ipv4fd_pkg::ActForward;
        d.target_iface = ipv4fd_pkg::IfaceW'(route);
      end else if (route == int'(h.arrival_iface)) begin
        d.action       = ipv4fd_pkg::ActSameIface;
        d.target_iface = ipv4fd_pkg::IfaceW'(route);
      end else if (h.hop_limit <= ipv4fd_pkg::TtlW'(1)) begin
        // No error can go out on an interface that does not exist.
        if (int'(h.arrival_iface) >= ipv4fd_pkg::NumIfaces) begin
          d.action = ipv4fd_pkg::ActTtlQuiet;
        end else begin
          d.target_iface = h.arrival_iface;
          if (h.protocol_number == ipv4fd_pkg::ProtoIcmp &&
              h.icmp_kind != ipv4fd_pkg::IcmpEcho &&
              h.icmp_kind != ipv4fd_pkg::IcmpEchoReply) d.action = ipv4fd_pkg::ActTtlQuiet;
          else d.action = ipv4fd_pkg::ActTtlError;
        end
      end else begin
        // Ones-complement add with the carry folded back in.
        sum_wide         = {1'b0, h.header_sum} + {1'b0, ipv4fd_pkg::TtlSumStep};
        d.action         = ipv4fd_pkg::ActForward;
        d.target_iface   = ipv4fd_pkg::IfaceW'(route);
        d.new_hop_limit  = h.hop_limit - ipv4fd_pkg::TtlW'(1);
        d.new_header_sum = sum_wide[ipv4fd_pkg::SumW-1:0] +
                           ipv4fd_pkg::SumW'(sum_wide[ipv4fd_pkg::SumW]);
      end
      return d;
    endfunction

    function void note_header(header_t h);
      pending.push_back(decide(h));
    endfunction

    function void check_decision(decision_t got);
      decision_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.action !== want.action) begin
        $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
        errors++;
      end
      if (got.target_iface !== want.target_iface) begin
        $display("%0t: target_iface expected %0d actual %0d", $time,
                 want.target_iface, got.target_iface);
        errors++;
      end
      if (got.new_hop_limit !== want.new_hop_limit) begin
        $display("%0t: new_hop_limit expected %h actual %h", $time,
                 want.new_hop_limit, got.new_hop_limit);
        errors++;
      end
      if (got.new_header_sum !== want.new_header_sum) begin
        $display("%0t: new_header_sum expected %h actual %h", $time,
                 want.new_header_sum, got.new_header_sum);
        errors++;
      end
    endfunction
  endclass

  logic                              clk   = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  cfg_index_t                        cfg_index = '0;
  addr_t                             cfg_data  = '0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [ipv4fd_pkg::InDataW-1:0]    s_tdata = '0;
  logic                              s_tuser = 1'b0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [ipv4fd_pkg::OutDataW-1:0]   m_tdata;
  action_t                           m_tuser;

  decision_scoreboard   sb = new();
  int                   src_burst  = 0;
  int                   sink_burst = 0;
  addr_t                next_addr [ipv4fd_pkg::IfaceSlots];
  addr_t                next_mask [ipv4fd_pkg::IfaceSlots];
  addr_t                next_gw;

  ipv4_forward_decision DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  // Idle cycles before the next beat, with occasional stretches of none.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic header_t build_header(logic lo, iface_t arr, addr_t dest, ttl_t ttl,
                                           sum_t sum, byte_t proto, byte_t kind);
    header_t h;
    h.locally_originated = lo;
    h.arrival_iface      = arr;
    h.dest_address       = dest;
    h.hop_limit          = ttl;
    h.header_sum         = sum;
    h.protocol_number    = proto;
    h.icmp_kind          = kind;
    return h;
  endfunction

  // Random header biased towards our addresses, subnets and the gateway.
  function automatic header_t random_header();
    header_t h;
    int      k;
    k = $urandom_range(0, ipv4fd_pkg::IfaceSlots - 1);
    h.locally_originated = ($urandom_range(0, 4) == 0);
    h.arrival_iface      = ipv4fd_pkg::IfaceW'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1:    h.dest_address = sb.iface_addr[k];
      2, 3, 4: h.dest_address = (sb.iface_addr[k] & sb.iface_mask[k]) |
                                ($urandom & ~sb.iface_mask[k]);
      5:       h.dest_address = sb.gateway;
      6:       h.dest_address = $urandom_range(0, 1) ? '1 : '0;
      default: h.dest_address = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0:       h.hop_limit = 8'd0;
      1:       h.hop_limit = 8'd1;
      2:       h.hop_limit = 8'd2;
      3:       h.hop_limit = 8'd255;
      default: h.hop_limit = ipv4fd_pkg::TtlW'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 7))
      0:       h.header_sum = 16'hFEFF;
      1:       h.header_sum = 16'hFF00 | ipv4fd_pkg::SumW'($urandom_range(0, 255));
      default: h.header_sum = ipv4fd_pkg::SumW'($urandom_range(0, 65535));
    endcase
    h.protocol_number = $urandom_range(0, 1) ? ipv4fd_pkg::ProtoIcmp :
                                               ipv4fd_pkg::ByteW'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       h.icmp_kind = ipv4fd_pkg::IcmpEcho;
      1:       h.icmp_kind = ipv4fd_pkg::IcmpEchoReply;
      default: h.icmp_kind = ipv4fd_pkg::ByteW'($urandom_range(0, 255));
    endcase
    return h;
  endfunction

  task automatic send_header(header_t h);
    int gap;
    bit took;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= h.locally_originated;
    s_tdata  <= {6'b0, h.icmp_kind, h.protocol_number, h.header_sum, h.hop_limit,
                 h.dest_address, h.arrival_iface};
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
  endtask

  // Writes every register in turn; the valid stays high across the run of beats.
  task automatic load_config();
    cfg_index_t idx_list [7];
    addr_t      val_list [7];
    bit         took;
    idx_list = '{ipv4fd_pkg::RegIf0Addr, ipv4fd_pkg::RegIf0Mask, ipv4fd_pkg::RegIf1Addr,
                 ipv4fd_pkg::RegIf1Mask, ipv4fd_pkg::RegIf2Addr, ipv4fd_pkg::RegIf2Mask,
                 ipv4fd_pkg::RegGateway};
    val_list = '{next_addr[0], next_mask[0], next_addr[1], next_mask[1],
                 next_addr[2], next_mask[2], next_gw};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      do begin
        @(negedge clk);
        took = cfg_ready;
        @(posedge clk);
      end while (!took);
      sb.write_reg(idx_list[i], val_list[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Lets the block empty out before the settings change.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_config();
    int p;
    foreach (next_addr[i]) begin
      next_addr[i] = $urandom;
      p = $urandom_range(0, 32);
      if ($urandom_range(0, 3) == 0) next_mask[i] = $urandom;
      else next_mask[i] = (p == 0) ? '0 : ('1 << (32 - p));
    end
    p = $urandom_range(0, ipv4fd_pkg::IfaceSlots - 1);
    if ($urandom_range(0, 1))
      next_gw = (next_addr[p] & next_mask[p]) | ($urandom & ~next_mask[p]);
    else
      next_gw = $urandom;
  endtask

  // Both stream beats are sampled between edges, where nothing changes.
  always @(negedge clk) begin
    if (rst_n) begin
      if (s_tvalid && s_tready)
        sb.note_header(build_header(s_tuser, s_tdata[1:0], s_tdata[33:2], s_tdata[41:34],
                                    s_tdata[57:42], s_tdata[65:58], s_tdata[73:66]));
      if (m_tvalid && m_tready)
        sb.check_decision({m_tuser, m_tdata[1:0], m_tdata[9:2], m_tdata[25:10]});
    end
  end

  // Result side: random stalls before each beat.
  initial begin
    int stall;
    bit took;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap(sink_burst);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        took = m_tvalid;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: every address is zero and every mask matches all.
    send_header(build_header(1'b0, 2'd1, 32'h0, 8'd64, 16'h1234, ProtoTcp, 8'd0));
    send_header(build_header(1'b0, 2'd1, 32'hDEADBEEF, 8'd64, 16'h1234, ProtoTcp, 8'd0));
    repeat (20) send_header(random_header());
    settle();

    // Directed headers against a typical three-subnet setup.
    next_addr = '{32'hC0A80101, 32'h0A000001, 32'hAC100501};
    next_mask = '{32'hFFFFFF00, 32'hFF000000, 32'hFFFF0000};
    next_gw   = 32'h0A0000FE;
    load_config();
    send_header(build_header(1'b0, 2'd1, 32'hC0A80101, 8'd64, 16'h1234, ProtoTcp, 8'd0));
    send_header(build_header(1'b0, 2'd2, 32'hAC100501, 8'd64, 16'h1234, ProtoTcp, 8'd0));
    send_header(build_header(1'b1, 2'd0, 32'hC0A80101, 8'd64, 16'h1234, ProtoTcp, 8'd0));
    send_header(build_header(1'b0, 2'd1, 32'hC0A80105, 8'd64, 16'h1234, ProtoUdp, 8'd0));
    send_header(build_header(1'b0, 2'd1, 32'hC0A80105, 8'd64, 16'hFEFF, ProtoUdp, 8'd0));
    send_header(build_header(1'b0, 2'd1, 32'hC0A80105, 8'd64, 16'hFF00, ProtoUdp, 8'd0));
    send_header(build_header(1'b0, 2'd2, 32'hC0A80105, 8'd64, 16'hFFFF, ProtoUdp, 8'd0));
    send_header(build_header(1'b0, 2'd2, 32'h0A123456, 8'd255, 16'h0000, ProtoTcp, 8'd0));
    send_header(build_header(1'b0, 2'd0, 32'h0A123456, 8'd2, 16'h8000, ProtoTcp, 8'd0));
    send_header(build_header(1'b0, 2'd0, 32'hC0A80107, 8'd64, 16'h1234, ProtoTcp, 8'd0));
    // Expired TTL: error for non-ICMP and echo traffic, silent otherwise.
    send_header(build_header(1'b0, 2'd2, 32'hC0A80107, 8'd1, 16'h1234, ProtoTcp, 8'd0));
    send_header(build_header(1'b0, 2'd1, 32'hC0A80107, 8'd0, 16'h1234, ipv4fd_pkg::ProtoIcmp,
                             ipv4fd_pkg::IcmpEcho));
    send_header(build_header(1'b0, 2'd2, 32'hC0A80107, 8'd1, 16'h1234, ipv4fd_pkg::ProtoIcmp,
                             ipv4fd_pkg::IcmpEchoReply));
    send_header(build_header(1'b0, 2'd1, 32'hC0A80107, 8'd1, 16'h1234, ipv4fd_pkg::ProtoIcmp,
                             IcmpTimeExceeded));
    // Arrival interface that does not exist.
    send_header(build_header(1'b0, 2'd3, 32'h0A777777, 8'd0, 16'h1234, ProtoTcp, 8'd0));
    send_header(build_header(1'b0, 2'd3, 32'hAC10FFFF, 8'd10, 16'h1234, ProtoTcp, 8'd0));
    // Fallback to the gateway route.
    send_header(build_header(1'b0, 2'd0, 32'h08080808, 8'd64, 16'h1234, ProtoTcp, 8'd0));
    // Locally originated traffic gets the lookup only.
    send_header(build_header(1'b1, 2'd1, 32'hC0A80109, 8'd0, 16'hFEFF, ipv4fd_pkg::ProtoIcmp,
                             IcmpUnreachable));
    send_header(build_header(1'b1, 2'd3, 32'h08080808, 8'd1, 16'h4321, ProtoTcp, 8'd0));
    send_header(build_header(1'b1, 2'd3, '1, '1, '1, '1, '1));
    send_header(build_header(1'b0, 2'd3, '1, '1, '1, '1, '1));
    send_header(build_header(1'b0, 2'd0, '0, '0, '0, '0, '0));
    settle();

    // Random phases, each with new settings; the first three are extremes.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          next_addr = '{'1, '1, '1};
          next_mask = '{'1, '1, '1};
          next_gw   = '1;
        end
        1: begin
          next_addr = '{$urandom, $urandom, $urandom};
          next_mask = '{'1, '1, '1};
          next_gw   = $urandom;
        end
        2: begin
          next_addr = '{$urandom, $urandom, $urandom};
          next_mask = '{'0, '0, '0};
          next_gw   = $urandom;
        end
        default: random_config();
      endcase
      load_config();
      // With host masks and a stray gateway most headers have no route.
      if (p == 1) begin
        send_header(build_header(1'b0, 2'd0, ~sb.iface_addr[0], 8'd64, 16'h1234, ProtoTcp,
                                 8'd0));
        send_header(build_header(1'b1, 2'd2, ~sb.iface_addr[1], 8'd64, 16'h1234, ProtoTcp,
                                 8'd0));
      end
      repeat (110) send_header(random_header());
      settle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
